### rtl/core/rrmq_pkg.sv
// Package for the range raise / minimum query store.
// Holds shared widths, parameter defaults and the sequencer state type.
`timescale 1ns / 1ps
`default_nettype none
package rrmq_pkg;
   localparam int PositionsDefault = 1024;
   localparam int PosWidth = 10;
   localparam int HeightWidth = 31;
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESP,
      ST_COMMIT,
      ST_CLEAR
   } state_type;
endpackage
`default_nettype wire

### rtl/core/range_raise_min_query_store_unit.sv
// Top level of the range raise / minimum query store.
// Depends on rrmq_pkg; holds the two height memories and the sequencer.
//
// Channel  Direction  Ports
// req      in         req_valid, req_ready, req_left, req_right, req_strength, req_batch_end
// rsp      out        rsp_valid, rsp_ready, rsp_breach
//
// A request is scanned one position per cycle through the two height memories, from left to right
// clipped to the last position, and no new request is taken until it is done; an empty range is not scanned.
// A request ending a batch is followed by the copy of pending into committed.
// After reset a clearing pass zeroes every position of both memories; no request is taken then.
// The response is held in a register until taken; no request is accepted before that cycle.
`timescale 1ns / 1ps
`default_nettype none
module range_raise_min_query_store_unit #(
   parameter int POSITIONS = rrmq_pkg::PositionsDefault
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wire logic [rrmq_pkg::PosWidth-1:0] req_left,
   input  wire logic [rrmq_pkg::PosWidth-1:0] req_right,
   input  wire logic [rrmq_pkg::HeightWidth-1:0] req_strength,
   input  wire logic req_batch_end,
   output logic rsp_valid,
   input  wire logic rsp_ready,
   output logic rsp_breach
);
   localparam int AW = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
   localparam int CW = AW + 1;
   localparam int HW = rrmq_pkg::HeightWidth;
   localparam int PW = rrmq_pkg::PosWidth;
   localparam int MW = (PW > CW) ? PW : CW;
   localparam logic [CW-1:0] LastPos = CW'(POSITIONS - 1);

   logic [HW-1:0] com_mem [POSITIONS];
   logic [HW-1:0] pen_mem [POSITIONS];

   rrmq_pkg::state_type state_ff, state_in;
   logic [CW-1:0] addr_ff, addr_in, hi_ff, hi_in;
   logic [HW-1:0] str_ff, str_in, least_ff, least_in;
   logic commit_ff, commit_in, rd_ff, rd_in;
   logic [AW-1:0] rd_addr_ff;
   logic [HW-1:0] com_rd_ff, pen_rd_ff;
   logic rsp_valid_ff, rsp_valid_in, breach_ff, breach_in;
   logic com_we, pen_we;
   logic [AW-1:0] com_wa, pen_wa;
   logic [HW-1:0] com_wd, pen_wd;
   logic [MW-1:0] lo_ext, hi_ext, clip_hi;

   always_ff @(posedge clock) begin
      com_rd_ff <= com_mem[addr_ff[AW-1:0]];
      pen_rd_ff <= pen_mem[addr_ff[AW-1:0]];
      if (com_we) com_mem[com_wa] <= com_wd;
      if (pen_we) pen_mem[pen_wa] <= pen_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrmq_pkg::ST_CLEAR;
         addr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_ff <= rd_in;
      end
      hi_ff <= hi_in;
      str_ff <= str_in;
      least_ff <= least_in;
      commit_ff <= commit_in;
      breach_ff <= breach_in;
      rd_addr_ff <= addr_ff[AW-1:0];
   end

   always_comb begin
      lo_ext = MW'(req_left);
      hi_ext = MW'(req_right);
      clip_hi = (hi_ext > MW'(LastPos)) ? MW'(LastPos) : hi_ext;
      state_in = state_ff;
      addr_in = addr_ff;
      hi_in = hi_ff;
      str_in = str_ff;
      least_in = least_ff;
      commit_in = commit_ff;
      breach_in = breach_ff;
      rd_in = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      com_we = 1'b0;
      pen_we = 1'b0;
      com_wa = rd_addr_ff;
      pen_wa = rd_addr_ff;
      com_wd = pen_rd_ff;
      pen_wd = str_ff;
      case (state_ff)
         rrmq_pkg::ST_CLEAR: begin
            com_we = 1'b1;
            pen_we = 1'b1;
            com_wa = addr_ff[AW-1:0];
            pen_wa = addr_ff[AW-1:0];
            com_wd = '0;
            pen_wd = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LastPos) begin
               addr_in = '0;
               state_in = rrmq_pkg::ST_IDLE;
            end
         end
         rrmq_pkg::ST_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               str_in = req_strength;
               commit_in = req_batch_end;
               least_in = '1;
               hi_in = CW'(clip_hi);
               addr_in = CW'(lo_ext);
               if (lo_ext <= clip_hi) begin
                  state_in = rrmq_pkg::ST_SCAN;
               end else begin
                  state_in = rrmq_pkg::ST_RESP;
               end
            end
         end
         rrmq_pkg::ST_SCAN: begin
            if (rd_ff) begin
               if (com_rd_ff < least_ff) least_in = com_rd_ff;
               pen_we = pen_rd_ff < str_ff;
            end
            if (addr_ff == hi_ff) begin
               state_in = rrmq_pkg::ST_RESP;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
            rd_in = 1'b1;
         end
         rrmq_pkg::ST_RESP: begin
            // Fold in the last position read during the scan, if any.
            if (rd_ff) begin
               if (com_rd_ff < least_ff) begin
                  breach_in = com_rd_ff < str_ff;
               end else begin
                  breach_in = least_ff < str_ff;
               end
               pen_we = pen_rd_ff < str_ff;
            end else begin
               breach_in = 1'b0;
            end
            rsp_valid_in = 1'b1;
            addr_in = '0;
            state_in = commit_ff ? rrmq_pkg::ST_COMMIT : rrmq_pkg::ST_IDLE;
         end
         rrmq_pkg::ST_COMMIT: begin
            // Each copy is written the cycle after its pending read; the last copy happens on exit.
            com_we = rd_ff;
            rd_in = addr_ff <= LastPos;
            addr_in = addr_ff + 1'b1;
            if (addr_ff > LastPos) begin
               state_in = rrmq_pkg::ST_IDLE;
               addr_in = '0;
            end
         end
         default: state_in = rrmq_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_breach = breach_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == rrmq_pkg::ST_IDLE) else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_breach))
      else $error("response dropped");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrmq_pkg::ST_SCAN |-> addr_ff <= hi_ff) else $error("scan overran");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrmq_pkg::ST_RESP |=> rsp_valid) else $error("no response");
endmodule
`default_nettype wire
